// ===== hdl/apvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apvt_pkg
// Shared widths, types, register codes and helpers of the affine point and
// vector transform unit.
// ----------------------------------------------------------------------------
package apvt_pkg;

  localparam int COEFF_WIDTH = 16;
  localparam int COORD_WIDTH = 32;
  localparam int COEFF_FRAC  = COEFF_WIDTH - 4;
  localparam int COORD_FRAC  = COORD_WIDTH / 2;

  localparam int ROW_WIDTH     = 64;
  localparam int WDIV_WIDTH    = 16;
  localparam int NUM_LANES     = 3;
  localparam int CFG_IDX_WIDTH = 2;

  // exact dot product: three products plus the translation term
  localparam int PROD_WIDTH = COEFF_WIDTH + COORD_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;
  // divisor magnitude: |w_divisor| or one in coefficient format
  localparam int DMAG_WIDTH = (COEFF_FRAC + 1 > WDIV_WIDTH) ? COEFF_FRAC + 1 : WDIV_WIDTH;
  // wide enough for the accumulator and for the divisor shifted past the quotient
  localparam int REM_WIDTH  = ACC_WIDTH + DMAG_WIDTH;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0 = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1 = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2 = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WDIV = CFG_IDX_WIDTH'(3);

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = ROW_WIDTH'(1) << COEFF_FRAC;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = ROW_WIDTH'(1) << (COEFF_WIDTH + COEFF_FRAC);
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET =
    ROW_WIDTH'(1) << (2 * COEFF_WIDTH + COEFF_FRAC);
  localparam logic [WDIV_WIDTH-1:0] WDIV_RESET = WDIV_WIDTH'(1) << COEFF_FRAC;

  typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   kind;
    coord_t x_in;
    coord_t y_in;
    coord_t z_in;
  } src_word_t;

  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
    coord_t z_out;
    logic   overflow;
    logic   zero_divisor;
  } dst_word_t;

  typedef struct packed {
    logic   valid;
    coord_t value;
    logic   sat;
    logic   zdiv;
  } lane_res_t;

  // entry j of a packed row; bits past the top of the row read as zero
  function automatic coeff_t row_entry(input logic [ROW_WIDTH-1:0] row, input int j);
    logic [ROW_WIDTH+4*COEFF_WIDTH-1:0] ext;
    ext = {{(4 * COEFF_WIDTH){1'b0}}, row};
    return coeff_t'(ext[j*COEFF_WIDTH +: COEFF_WIDTH]);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/apvt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apvt_lane
// One output component: row dot product, translation, then a restoring
// divider pipelined one quotient bit per stage, sign and saturation.
// ----------------------------------------------------------------------------
module apvt_lane
  import apvt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   src_valid,
  input  wire src_word_t              src_word,
  input  wire logic [ROW_WIDTH-1:0]   row,
  input  wire logic [WDIV_WIDTH-1:0]  w_div,
  output lane_res_t                   res
);

  localparam int L = COORD_WIDTH;

  coeff_t                 e [4];
  coord_t                 c [3];
  logic                   accept;
  logic                   is_point;
  logic [WDIV_WIDTH-1:0]  w_abs;

  // multiply stage
  logic                          vld1;
  logic signed [PROD_WIDTH-1:0]  prod1 [3];
  logic signed [ACC_WIDTH-1:0]   trans1;
  logic [DMAG_WIDTH-1:0]         dmag1;
  logic                          dneg1;
  logic                          zd1;

  // sum stage
  logic                          vld2;
  logic signed [ACC_WIDTH-1:0]   acc2;
  logic [DMAG_WIDTH-1:0]         dmag2;
  logic                          dneg2;
  logic                          zd2;
  logic [ACC_WIDTH-1:0]          acc_mag;

  // divider stages, index 0 is the set-up stage
  logic                   vld    [L+1];
  logic [REM_WIDTH-1:0]   rem    [L];
  logic [L-1:0]           quo    [L+1];
  logic [DMAG_WIDTH-1:0]  dmag   [L];
  logic                   ovf    [L+1];
  logic                   qneg   [L+1];
  logic                   accneg [L+1];
  logic                   zero   [L+1];
  logic                   zd     [L+1];

  assign accept   = src_valid && adv;
  assign is_point = (src_word.kind == KIND_POINT);
  assign c[0]     = src_word.x_in;
  assign c[1]     = src_word.y_in;
  assign c[2]     = src_word.z_in;
  assign w_abs    = w_div[WDIV_WIDTH-1] ? (~w_div + WDIV_WIDTH'(1)) : w_div;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      e[j] = row_entry(row, j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld1 <= accept;
      vld2 <= vld1;
      vld[0] <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        prod1[j] <= PROD_WIDTH'(e[j]) * PROD_WIDTH'(c[j]);
      end
      trans1 <= is_point ? (ACC_WIDTH'(e[3]) <<< COORD_FRAC) : '0;
      // vectors divide by one in coefficient format
      dmag1  <= is_point ? DMAG_WIDTH'(w_abs) : (DMAG_WIDTH'(1) << COEFF_FRAC);
      dneg1  <= is_point && w_div[WDIV_WIDTH-1];
      zd1    <= is_point && (w_div == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc2  <= ACC_WIDTH'(prod1[0]) + ACC_WIDTH'(prod1[1]) + ACC_WIDTH'(prod1[2]) + trans1;
      dmag2 <= dmag1;
      dneg2 <= dneg1;
      zd2   <= zd1;
    end
  end

  assign acc_mag = acc2[ACC_WIDTH-1] ? ACC_WIDTH'(-acc2) : ACC_WIDTH'(acc2);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]    <= REM_WIDTH'(acc_mag);
      quo[0]    <= '0;
      dmag[0]   <= dmag2;
      // quotient of 2^L or more saturates whatever its sign
      ovf[0]    <= REM_WIDTH'(acc_mag) >= (REM_WIDTH'(dmag2) << L);
      qneg[0]   <= acc2[ACC_WIDTH-1] ^ dneg2;
      accneg[0] <= acc2[ACC_WIDTH-1];
      zero[0]   <= (acc2 == '0);
      zd[0]     <= zd2;
    end
  end

  for (genvar s = 0; s < L; s++) begin : g_div
    localparam int K = L - 1 - s;
    logic [REM_WIDTH-1:0] trial;
    logic                 fits;

    assign trial = REM_WIDTH'(dmag[s]) << K;
    assign fits  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo[s+1]    <= fits ? (quo[s] | (L'(1) << K)) : quo[s];
        ovf[s+1]    <= ovf[s];
        qneg[s+1]   <= qneg[s];
        accneg[s+1] <= accneg[s];
        zero[s+1]   <= zero[s];
        zd[s+1]     <= zd[s];
      end
    end

    if (s < L - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[s+1]  <= fits ? (rem[s] - trial) : rem[s];
          dmag[s+1] <= dmag[s];
        end
      end
    end
  end

  localparam logic [L-1:0] MAX_POS = {1'b0, {(L-1){1'b1}}};
  localparam logic [L-1:0] MIN_NEG = {1'b1, {(L-1){1'b0}}};

  always_comb begin
    res.valid = vld[L];
    res.zdiv  = zd[L];
    if (zd[L]) begin
      res.sat   = !zero[L];
      res.value = zero[L] ? '0 : (accneg[L] ? coord_t'(MIN_NEG) : coord_t'(MAX_POS));
    end else if (ovf[L] || (!qneg[L] && quo[L][L-1]) || (qneg[L] && quo[L] > MIN_NEG)) begin
      res.sat   = 1'b1;
      res.value = qneg[L] ? coord_t'(MIN_NEG) : coord_t'(MAX_POS);
    end else begin
      res.sat   = 1'b0;
      res.value = qneg[L] ? coord_t'(-quo[L]) : coord_t'(quo[L]);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/apvt_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apvt_merge
// Joins the three lane results into one output word, ors the saturation
// flags, and holds it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module apvt_merge
  import apvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lane_res_t  lane_res [NUM_LANES],
  input  wire logic       dst_stall,
  output logic            dst_valid,
  output dst_word_t       dst_word,
  output logic            skid_valid
);

  dst_word_t               word_now;
  dst_word_t               skid_word;
  logic [NUM_LANES-1:0]    lane_valid;
  logic                    take;
  logic                    load;
  logic                    dst_load;
  logic                    skid_load;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_valid[i] = lane_res[i].valid;
    end
  end

  assign word_now.x_out        = lane_res[0].value;
  assign word_now.y_out        = lane_res[1].value;
  assign word_now.z_out        = lane_res[2].value;
  assign word_now.overflow     = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
  assign word_now.zero_divisor = lane_res[0].zdiv;

  // lanes only advance while the skid register is empty
  assign take      = dst_valid && !dst_stall;
  assign load      = lane_valid[0] && !skid_valid;
  assign dst_load  = load && (!dst_valid || take);
  assign skid_load = load && dst_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          skid_valid <= 1'b0;
        end
      end else if (dst_load) begin
        dst_valid <= 1'b1;
      end else if (skid_load) begin
        skid_valid <= 1'b1;
      end else if (take) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      dst_word <= skid_word;
    end else if (dst_load) begin
      dst_word <= word_now;
    end
    if (skid_load) begin
      skid_word <= word_now;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> dst_valid)
    else $error("skid word held with no output word");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_valid == '0 || lane_valid == '1)
    else $error("lanes out of step");

  a_frozen_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && lane_valid[0] |=> lane_valid[0])
    else $error("lane word lost while pipeline held");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall && !skid_valid && lane_valid[0] |=> skid_valid)
    else $error("stalled result not caught by skid register");

  a_zdiv_value: assert property (@(posedge clk) disable iff (rst)
    lane_res[0].valid && lane_res[0].zdiv && !lane_res[0].sat |-> lane_res[0].value == '0)
    else $error("zero divisor result neither saturated nor zero");

endmodule
`default_nettype wire

// ===== hdl/affine_point_vector_transform_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_point_vector_transform_unit
// Transforms one point or direction vector per word by the upper three rows
// of a configured 4x4 matrix, with division of points by the w entry.
//
// Input channel src_valid / src_stall / src_word carries kind and x, y, z.
// Output channel dst_valid / dst_stall / dst_word carries the transformed
// x, y, z and the overflow and zero_divisor flags, one word per input word,
// in order. The config channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// writes the three matrix rows and w_divisor; cfg_ready is always high and
// writes are meant for an idle block.
// Throughput is one word per cycle while src_stall is low. From the accepting
// edge to dst_valid, a word passes these registers in order:
// the multiply stage loads on the accepting edge, then come the sum
// stage, one divider set-up stage, one stage per quotient bit in each
// lane's restoring divider, and the output register.
// When the receiver stalls, the output register holds its word and one more
// lands in the skid register; the lanes then freeze and src_stall rises
// until the skid word moves out. Reset empties the pipeline and loads the
// identity matrix.
// ----------------------------------------------------------------------------
module affine_point_vector_transform_unit
  import apvt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      src_valid,
  output logic                           src_stall,
  input  wire src_word_t                 src_word,
  output logic                           dst_valid,
  input  wire logic                      dst_stall,
  output dst_word_t                      dst_word,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [ROW_WIDTH-1:0]      cfg_data
);

  logic [ROW_WIDTH-1:0]   rows [NUM_LANES];
  logic [WDIV_WIDTH-1:0]  w_div;
  lane_res_t              lane_res [NUM_LANES];
  logic                   skid_valid;
  logic                   adv;

  assign cfg_ready = 1'b1;
  assign adv       = !skid_valid;
  assign src_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW0_RESET;
      rows[1] <= ROW1_RESET;
      rows[2] <= ROW2_RESET;
      w_div   <= WDIV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0: rows[0] <= cfg_data;
        REG_ROW1: rows[1] <= cfg_data;
        REG_ROW2: rows[2] <= cfg_data;
        REG_WDIV: w_div   <= cfg_data[WDIV_WIDTH-1:0];
      endcase
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    apvt_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .src_valid (src_valid),
      .src_word  (src_word),
      .row       (rows[i]),
      .w_div     (w_div),
      .res       (lane_res[i])
    );
  end

  apvt_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_res   (lane_res),
    .dst_stall  (dst_stall),
    .dst_valid  (dst_valid),
    .dst_word   (dst_word),
    .skid_valid (skid_valid)
  );

endmodule
`default_nettype wire
